// ===== hw/rtl/osp_pkg.sv =====
// Package for the obstacle segment projector: coordinate types, port words,
// register indexes and the saturation helper. No dependencies.
package osp_pkg;

	localparam int FracBitsDef = 16;
	localparam int CoordW      = 32;
	localparam int IdxW        = 3;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [2:0][CoordW-1:0] coord3_t;

	typedef enum logic [IdxW-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_GOAL_X  = 3'd3,
		REG_GOAL_Y  = 3'd4,
		REG_GOAL_Z  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		coord_t obs_x;
		coord_t obs_y;
		coord_t obs_z;
	} obs_t;

	typedef struct packed {
		logic   kept;
		coord_t push_x;
		coord_t push_y;
		coord_t push_z;
		coord_t along;
	} res_t;

	// Handoff from the projection pipe to the distance pipe.
	typedef struct packed {
		logic    valid;
		logic    kept;
		coord_t  along;
		coord3_t p;
	} proj_t;

	localparam logic signed [35:0] SatMax = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] SatMin = 36'shF_8000_0000;

	function automatic coord_t sat32(input logic signed [35:0] v);
		coord_t r;
		if (v > SatMax) begin
			r = coord_t'(SatMax[31:0]);
		end else if (v < SatMin) begin
			r = coord_t'(SatMin[31:0]);
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/osp_cfg.sv =====
// Configuration registers for the obstacle segment projector.
// Holds start and goal and keeps the saturated line vector ready. Uses osp_pkg.
module osp_cfg import osp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  logic [IdxW-1:0]     index,
	input  coord_t              data,
	output coord3_t             s,
	output coord3_t             ln
);

	coord_t start_q [3];
	coord_t goal_q  [3];
	coord_t ln_q    [3];

	// The line vector is updated together with the register, so it is valid
	// in the cycle after the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				goal_q[i]  <= '0;
				ln_q[i]    <= '0;
			end
		end else if (wr) begin
			case (index)
				REG_START_X, REG_START_Y, REG_START_Z: begin
					start_q[index[1:0]] <= data;
					ln_q[index[1:0]]    <= sat32(36'(goal_q[index[1:0]]) - 36'(data));
				end
				REG_GOAL_X: begin
					goal_q[0] <= data;
					ln_q[0]   <= sat32(36'(data) - 36'(start_q[0]));
				end
				REG_GOAL_Y: begin
					goal_q[1] <= data;
					ln_q[1]   <= sat32(36'(data) - 36'(start_q[1]));
				end
				REG_GOAL_Z: begin
					goal_q[2] <= data;
					ln_q[2]   <= sat32(36'(data) - 36'(start_q[2]));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			s[i]  = start_q[i];
			ln[i] = ln_q[i];
		end
	end

endmodule

// ===== hw/rtl/osp_proj.sv =====
// Projection pipe: dot product, squared length, range test on u and a
// pipelined restoring divider that yields u. Uses osp_pkg.
module osp_proj import osp_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  obs_t    obs,
	input  coord3_t ln,
	output proj_t   out
);

	localparam int F = FRAC_BITS;

	coord3_t            p_in;
	logic signed [63:0] pr_s1  [3];
	logic signed [63:0] lsq_s1 [3];
	coord3_t            p_s1, p_s2, p_s3;
	logic               v_s1, v_s2, v_s3;
	logic signed [65:0] dot_s2;
	logic [63:0]        norm_s2, norm_s3, mag_s3;
	logic               dneg_s3;

	// Divider pipe; entry 0 is the stage that sets up the integer bit.
	logic [63:0] rem_sd  [0:F];
	logic [63:0] norm_sd [0:F];
	logic [F:0]  quo_sd  [0:F];
	logic        dneg_sd [0:F];
	logic        keep_sd [0:F];
	logic        v_sd    [0:F];
	coord3_t     p_sd    [0:F];

	logic [67:0] mag5, mag10, norm11;
	logic        q0;
	coord_t      qz;
	logic        valid_q;
	logic        kept_q;
	coord_t      along_q;
	coord3_t     p_q;

	assign p_in = {obs.obs_z, obs.obs_y, obs.obs_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_sd[0] <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_sd[0] <= v_s3;
			valid_q <= v_sd[F];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pr_s1[i]  <= $signed(p_in[i]) * $signed(ln[i]);
			lsq_s1[i] <= $signed(ln[i]) * $signed(ln[i]);
		end
		p_s1 <= p_in;

		dot_s2  <= 66'(pr_s1[0]) + 66'(pr_s1[1]) + 66'(pr_s1[2]);
		norm_s2 <= 64'(lsq_s1[0]) + 64'(lsq_s1[1]) + 64'(lsq_s1[2]);
		p_s2    <= p_s1;

		dneg_s3 <= dot_s2[65];
		mag_s3  <= dot_s2[65] ? 64'(-dot_s2) : dot_s2[63:0];
		norm_s3 <= norm_s2;
		p_s3    <= p_s2;
	end

	// Keep iff -0.2 < u < 1.1, done exactly; a zero norm fails both tests.
	assign mag5   = {2'b0, mag_s3, 2'b0} + 68'(mag_s3);
	assign mag10  = {1'b0, mag_s3, 3'b0} + {3'b0, mag_s3, 1'b0};
	assign norm11 = {1'b0, norm_s3, 3'b0} + {3'b0, norm_s3, 1'b0} + 68'(norm_s3);
	assign q0     = mag_s3 >= norm_s3;

	always_ff @(posedge clk) begin
		keep_sd[0] <= dneg_s3 ? (mag5 < 68'(norm_s3)) : (mag10 < norm11);
		rem_sd[0]  <= q0 ? mag_s3 - norm_s3 : mag_s3;
		quo_sd[0]  <= (F+1)'(q0);
		norm_sd[0] <= norm_s3;
		dneg_sd[0] <= dneg_s3;
		p_sd[0]    <= p_s3;
	end

	for (genvar j = 1; j <= F; j++) begin : g_div
		logic [64:0] r2;
		logic        ge;
		assign r2 = {rem_sd[j-1], 1'b0};
		assign ge = r2 >= {1'b0, norm_sd[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else begin
				v_sd[j] <= v_sd[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[j]  <= ge ? 64'(r2 - {1'b0, norm_sd[j-1]}) : r2[63:0];
			quo_sd[j]  <= {quo_sd[j-1][F-1:0], ge};
			norm_sd[j] <= norm_sd[j-1];
			dneg_sd[j] <= dneg_sd[j-1];
			keep_sd[j] <= keep_sd[j-1];
			p_sd[j]    <= p_sd[j-1];
		end
	end

	assign qz = coord_t'(quo_sd[F]);

	always_ff @(posedge clk) begin
		kept_q  <= keep_sd[F];
		along_q <= dneg_sd[F] ? -qz : qz;
		p_q     <= p_sd[F];
	end

	assign out = '{valid: valid_q, kept: kept_q, along: along_q, p: p_q};

endmodule

// ===== hw/rtl/osp_dist.sv =====
// Distance pipe: projected point, offset, distance test, pipelined integer
// square root and the pushed point with saturation. Uses osp_pkg.
module osp_dist import osp_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  proj_t   pin,
	input  coord3_t s,
	input  coord3_t ln,
	output logic    res_valid,
	output res_t    res
);

	localparam int F   = FRAC_BITS;
	localparam int XW  = 34;
	localparam int DXW = 35;
	localparam int DW  = F + 4;
	localparam int RW  = F + 3;
	localparam int SQW = 2 * F + 7;
	localparam int PW  = 2 * DW;
	localparam logic signed [DXW-1:0] Lim   = DXW'(5) <<< F;
	localparam logic [SQW-1:0]        SqLim = SQW'(25) << (2 * F);
	localparam logic signed [DW-1:0]  Two   = DW'(2) <<< F;

	logic signed [63:0]    m_s1  [3];
	coord3_t               p_s1;
	coord_t                u_s1, u_s2, u_s3;
	logic                  k_s1, k_s2, k_s3;
	logic                  v_s1, v_s2, v_s3;
	logic signed [XW-1:0]  x_s2  [3];
	logic signed [DXW-1:0] dx_s2 [3];
	logic signed [XW-1:0]  x_s3  [3];
	logic signed [DW-1:0]  dn_s3 [3];
	logic [SQW-1:0]        sq_s3 [3];
	logic [SQW-1:0]        sq_sum;
	logic                  in_box;

	// Square root pipe; entry 0 is the stage after the distance test.
	logic [2*RW-1:0]      rad_sr  [0:RW];
	logic [RW+1:0]        rem_sr  [0:RW];
	logic [RW-1:0]        root_sr [0:RW];
	logic signed [XW-1:0] x_sr    [0:RW][3];
	logic signed [DW-1:0] dn_sr   [0:RW][3];
	coord_t               u_sr    [0:RW];
	logic                 k_sr    [0:RW];
	logic                 v_sr    [0:RW];

	logic signed [DW-1:0]  fac;
	logic signed [PW-1:0]  pp_s5 [3];
	logic signed [XW-1:0]  x_s5  [3];
	coord_t                u_s5;
	logic                  k_s5, v_s5;
	coord_t                push  [3];
	logic                  res_valid_q;
	res_t                  res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_sr[0] <= 1'b0;
			v_s5 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= pin.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_sr[0] <= v_s3;
			v_s5 <= v_sr[RW];
			res_valid_q <= v_s5;
		end
	end

	always_comb begin
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (dx_s2[i] >= Lim || dx_s2[i] <= -Lim) begin
				in_box = 1'b0;
			end
		end
		sq_sum = sq_s3[0] + sq_s3[1] + sq_s3[2];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s1[i] <= $signed(pin.along) * $signed(ln[i]);
		end
		p_s1 <= pin.p;
		u_s1 <= pin.along;
		k_s1 <= pin.kept;

		for (int i = 0; i < 3; i++) begin
			x_s2[i]  <= XW'($signed(s[i])) + XW'(m_s1[i] >>> F);
			dx_s2[i] <= DXW'(XW'($signed(s[i])) + XW'(m_s1[i] >>> F))
				- DXW'($signed(p_s1[i]));
		end
		u_s2 <= u_s1;
		k_s2 <= k_s1;

		for (int i = 0; i < 3; i++) begin
			x_s3[i]  <= x_s2[i];
			dn_s3[i] <= dx_s2[i][DW-1:0];
			sq_s3[i] <= SQW'(PW'($signed(dx_s2[i][DW-1:0]))
				* PW'($signed(dx_s2[i][DW-1:0])));
		end
		u_s3 <= u_s2;
		k_s3 <= k_s2 && in_box;

		rad_sr[0]  <= sq_sum[2*RW-1:0];
		rem_sr[0]  <= '0;
		root_sr[0] <= '0;
		x_sr[0]    <= x_s3;
		dn_sr[0]   <= dn_s3;
		u_sr[0]    <= u_s3;
		k_sr[0]    <= k_s3 && (sq_sum < SqLim);
	end

	// One root bit per stage, two radicand bits consumed each time.
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+1:0] remn, trial;
		assign remn  = {rem_sr[k][RW-1:0], rad_sr[k][2*(RW-1-k)+1 -: 2]};
		assign trial = {root_sr[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sr[k+1] <= 1'b0;
			end else begin
				v_sr[k+1] <= v_sr[k];
			end
		end

		always_ff @(posedge clk) begin
			if (remn >= trial) begin
				rem_sr[k+1]  <= remn - trial;
				root_sr[k+1] <= {root_sr[k][RW-2:0], 1'b1};
			end else begin
				rem_sr[k+1]  <= remn;
				root_sr[k+1] <= {root_sr[k][RW-2:0], 1'b0};
			end
			rad_sr[k+1] <= rad_sr[k];
			x_sr[k+1]   <= x_sr[k];
			dn_sr[k+1]  <= dn_sr[k];
			u_sr[k+1]   <= u_sr[k];
			k_sr[k+1]   <= k_sr[k];
		end
	end

	assign fac = Two - $signed({1'b0, root_sr[RW]});

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pp_s5[i] <= dn_sr[RW][i] * fac;
		end
		x_s5 <= x_sr[RW];
		u_s5 <= u_sr[RW];
		k_s5 <= k_sr[RW];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			push[i] = sat32(36'(x_s5[i]) + 36'(pp_s5[i] >>> (F + 1)));
		end
	end

	always_ff @(posedge clk) begin
		res_q.kept   <= k_s5;
		res_q.push_x <= k_s5 ? push[0] : '0;
		res_q.push_y <= k_s5 ? push[1] : '0;
		res_q.push_z <= k_s5 ? push[2] : '0;
		res_q.along  <= k_s5 ? u_s5 : '0;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/obstacle_segment_projector_unit.sv =====
// Top level of the obstacle segment projector.
// Instantiates osp_cfg, osp_proj and osp_dist; uses osp_pkg.
//
//  Channel   Handshake                  Word
//  -------   ------------------------   ------------------------------------
//  input     start & !busy              obs   (obs_x, obs_y, obs_z)
//  result    res_valid, one cycle       res   (kept, push_x/y/z, along)
//  config    cfg_valid & cfg_ready      cfg_index, cfg_data
//
// The block takes one input word in every cycle; busy stays low. Each word
// gives exactly one result word, in Q16.16 for the default FRAC_BITS. The
// divider yields one quotient bit per stage and the square root one root
// bit per stage. The result is shown for one cycle and cannot be held off.
// Reset clears the configuration registers and the valid bits, which empties
// the pipeline; configuration writes are taken in every cycle.
module obstacle_segment_projector_unit import osp_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  obs_t            obs,
	output logic            res_valid,
	output res_t            res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [IdxW-1:0] cfg_index,
	input  coord_t          cfg_data
);

	coord3_t s;
	coord3_t ln;
	proj_t   proj;
	logic    accept;

	// The pipeline never stalls, so neither channel pushes back.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Start and goal registers; the line vector is kept saturated alongside.
	osp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.s      (s),
		.ln     (ln)
	);

	// Dot product, range test and division give u for each word.
	osp_proj #(
		.FRAC_BITS (FRAC_BITS)
	) u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.obs      (obs),
		.ln       (ln),
		.out      (proj)
	);

	// Projected point, distance, square root and the pushed point.
	osp_dist #(
		.FRAC_BITS (FRAC_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.pin       (proj),
		.s         (s),
		.ln        (ln),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
